FILE: rtl/core/rcpf_pkg.sv
// Shared types and constants for the RC pulse capture and failsafe block.
// No dependencies; every other file of the block imports this package.
package rcpf_pkg;

   localparam int CHANNELS   = 6;
   localparam int CTRL_CH    = 4;   // throttle, roll, pitch, yaw
   localparam int LVL_W      = 12;
   localparam int TMO_W      = 24;
   localparam int MASK_W     = 3;
   localparam int TIME_W     = 32;
   localparam int EDGE_W     = 16;  // falling edge width is kept to 16 bits
   localparam int OUT_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // request kinds
   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   // channel numbers
   localparam logic [2:0] CH_THROTTLE = 3'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_FAILSAFE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_CUT       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_TMO     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FAILSAFE_DLY  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUIRED_MASK = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_FLOOR     = 3'd7;

   typedef struct packed {
      logic              kind;
      logic [2:0]        channel;
      logic              level;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic             failsafe;
      logic             loss_pending;
      logic             throttle_cut;
      logic             controls_valid;
      logic [OUT_W-1:0] throttle_us;
      logic [OUT_W-1:0] roll_us;
      logic [OUT_W-1:0] pitch_us;
      logic [OUT_W-1:0] yaw_us;
      logic [OUT_W-1:0] aux1_us;
      logic [OUT_W-1:0] aux2_us;
   } rsp_type;

   typedef struct packed {
      logic [LVL_W-1:0]  pulse_min_us;
      logic [LVL_W-1:0]  pulse_max_us;
      logic [LVL_W-1:0]  throttle_failsafe_level;
      logic [LVL_W-1:0]  throttle_cut_level;
      logic [TMO_W-1:0]  stale_timeout_us;
      logic [TMO_W-1:0]  failsafe_delay_us;
      logic [MASK_W-1:0] required_mask;
      logic [LVL_W-1:0]  throttle_floor_us;
   } cfg_type;

endpackage

FILE: rtl/core/rcpf_csr.sv
// Configuration register bank of the RC pulse capture and failsafe block.
// Depends on rcpf_pkg for the register indexes and the cfg_type bundle.
module rcpf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rcpf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcpf_pkg::CSR_DATA_W-1:0]  csr_data,
   output rcpf_pkg::cfg_type                cfg
);
   import rcpf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PULSE_MIN:     cfg_in.pulse_min_us            = csr_data[LVL_W-1:0];
            CSR_PULSE_MAX:     cfg_in.pulse_max_us            = csr_data[LVL_W-1:0];
            CSR_THR_FAILSAFE:  cfg_in.throttle_failsafe_level = csr_data[LVL_W-1:0];
            CSR_THR_CUT:       cfg_in.throttle_cut_level      = csr_data[LVL_W-1:0];
            CSR_STALE_TMO:     cfg_in.stale_timeout_us        = csr_data[TMO_W-1:0];
            CSR_FAILSAFE_DLY:  cfg_in.failsafe_delay_us       = csr_data[TMO_W-1:0];
            CSR_REQUIRED_MASK: cfg_in.required_mask           = csr_data[MASK_W-1:0];
            CSR_THR_FLOOR:     cfg_in.throttle_floor_us       = csr_data[LVL_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min_us            <= 12'd900;
         cfg_ff.pulse_max_us            <= 12'd2100;
         cfg_ff.throttle_failsafe_level <= 12'd950;
         cfg_ff.throttle_cut_level      <= 12'd1050;
         cfg_ff.stale_timeout_us        <= 24'd100000;
         cfg_ff.failsafe_delay_us       <= 24'd2000000;
         cfg_ff.required_mask           <= 3'd7;
         cfg_ff.throttle_floor_us       <= 12'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/rc_pwm_capture_failsafe_unit.sv
// Top level of the six-channel RC servo pulse capture with failsafe.
// Depends on rcpf_pkg and instantiates rcpf_csr.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   req     | in        | req_valid/req_stall | rcpf_pkg::req_type (edge or eval)
//   rsp     | out       | rsp_valid/rsp_stall | rcpf_pkg::rsp_type (one per eval)
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data (ready high)
//
// A request is held in the input register, where it is resolved against
// the channel state; an evaluate result is written into the result register
// as the request leaves it. One request per cycle is taken unless req_stall is high.
// An edge request never waits on rsp_stall; an evaluate request waits in the
// input register only while the previous result is still held by rsp_stall.
// Synchronous active-high reset clears channel state and loads register defaults.
module rc_pwm_capture_failsafe_unit #(
   parameter int PULSE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rcpf_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rcpf_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rcpf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcpf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rcpf_pkg::*;

   localparam int CMP_W = 16;

   cfg_type cfg;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    s1_go;
   logic    s1_eval;

   // per-channel state
   logic [EDGE_W-1:0]     rise_ff    [CHANNELS];
   logic [EDGE_W-1:0]     rise_in    [CHANNELS];
   logic [PULSE_BITS-1:0] capt_ff    [CHANNELS];
   logic [PULSE_BITS-1:0] capt_in    [CHANNELS];
   logic [TIME_W-1:0]     capt_t_ff  [CHANNELS];
   logic [TIME_W-1:0]     capt_t_in  [CHANNELS];
   logic [PULSE_BITS-1:0] held_ff    [CHANNELS];
   logic [PULSE_BITS-1:0] held_in    [CHANNELS];

   logic              failsafe_ff, failsafe_in;
   logic              loss_ff, loss_in;
   logic [TIME_W-1:0] loss_t_ff, loss_t_in;

   // evaluate terms
   logic [CTRL_CH-1:0] stale;
   logic               timeout;
   logic               rx_failsafe;
   logic               cut;
   logic               good;
   logic [CMP_W-1:0]   thr;
   logic [TIME_W-1:0]  loss_age;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   rcpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Advance the input register unless an evaluate result would overrun a
   // stalled result register.
   assign s1_eval   = s1_ff.kind == KIND_EVAL;
   assign s1_go     = s1_valid_ff && (!s1_eval || !out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
      end
   end

   // Edge capture: a rise stores the low time bits, a fall measures the
   // 16-bit width and keeps it only inside [min, max].
   always_comb begin
      logic [EDGE_W-1:0] width;
      for (int i = 0; i < CHANNELS; i++) begin
         rise_in[i]   = rise_ff[i];
         capt_in[i]   = capt_ff[i];
         capt_t_in[i] = capt_t_ff[i];
         width = s1_ff.time_us[EDGE_W-1:0] - rise_ff[i];
         if (s1_go && !s1_eval && s1_ff.channel == 3'(i)) begin
            if (s1_ff.level) begin
               rise_in[i] = s1_ff.time_us[EDGE_W-1:0];
            end else if (width >= EDGE_W'(cfg.pulse_min_us) &&
                         width <= EDGE_W'(cfg.pulse_max_us)) begin
               capt_in[i]   = width[PULSE_BITS-1:0];
               capt_t_in[i] = s1_ff.time_us;
            end
         end
      end
   end

   // Evaluate: classify throttle, check required channels for staleness.
   always_comb begin
      logic [TIME_W-1:0] age;
      for (int i = 0; i < CTRL_CH; i++) begin
         age      = s1_ff.time_us - capt_t_ff[i];
         stale[i] = age >= TIME_W'(cfg.stale_timeout_us);
      end
   end

   assign timeout     = |(cfg.required_mask & stale[CTRL_CH-1:1]);
   assign thr         = CMP_W'(capt_ff[CH_THROTTLE]);
   assign rx_failsafe = thr < CMP_W'(cfg.throttle_failsafe_level);
   assign cut         = rx_failsafe || thr < CMP_W'(cfg.throttle_cut_level) || stale[0];
   assign good        = !(timeout || rx_failsafe);
   assign loss_age    = s1_ff.time_us - loss_t_ff;

   always_comb begin
      failsafe_in = failsafe_ff;
      loss_in     = loss_ff;
      loss_t_in   = loss_t_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         held_in[i] = held_ff[i];
      end
      if (s1_go && s1_eval) begin
         if (good) begin
            // signal good: drop loss state, refresh held values
            failsafe_in = 1'b0;
            loss_in     = 1'b0;
            held_in[0]  = cut ? PULSE_BITS'(cfg.throttle_floor_us) : capt_ff[0];
            for (int i = 1; i < CHANNELS; i++) begin
               held_in[i] = capt_ff[i];
            end
         end else if (!loss_ff) begin
            // first lost evaluate only starts the loss timer
            loss_in   = 1'b1;
            loss_t_in = s1_ff.time_us;
         end else if (loss_age >= TIME_W'(cfg.failsafe_delay_us)) begin
            failsafe_in = 1'b1;
         end
      end
   end

   // Result built from the state as it stands after this evaluate.
   always_comb begin
      out_in                = out_ff;
      out_valid_in          = out_valid_ff;
      if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (s1_go && s1_eval) begin
         out_valid_in          = 1'b1;
         out_in.failsafe       = failsafe_in;
         out_in.loss_pending   = loss_in;
         out_in.throttle_cut   = cut;
         out_in.controls_valid = !(failsafe_in || loss_in);
         out_in.throttle_us    = OUT_W'(held_in[0]);
         out_in.roll_us        = OUT_W'(held_in[1]);
         out_in.pitch_us       = OUT_W'(held_in[2]);
         out_in.yaw_us         = OUT_W'(held_in[3]);
         out_in.aux1_us        = OUT_W'(held_in[4]);
         out_in.aux2_us        = OUT_W'(held_in[5]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         failsafe_ff  <= 1'b0;
         loss_ff      <= 1'b0;
         loss_t_ff    <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            rise_ff[i]   <= '0;
            capt_ff[i]   <= '0;
            capt_t_ff[i] <= '0;
            held_ff[i]   <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         failsafe_ff  <= failsafe_in;
         loss_ff      <= loss_in;
         loss_t_ff    <= loss_t_in;
         for (int i = 0; i < CHANNELS; i++) begin
            rise_ff[i]   <= rise_in[i];
            capt_ff[i]   <= capt_in[i];
            capt_t_ff[i] <= capt_t_in[i];
            held_ff[i]   <= held_in[i];
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_ff <= req_data;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: rtl/core/rcpf_checker.sv
// Port-level checks for rc_pwm_capture_failsafe_unit, bound to the top level.
// Depends on rcpf_pkg for the response type.
module rcpf_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rcpf_pkg::rsp_type rsp_data
);
   import rcpf_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // failsafe only asserts while the loss timer runs
   a_fs_loss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.failsafe |-> rsp_data.loss_pending)
      else $error("failsafe without loss pending");

   // controls valid exactly when no loss is seen
   a_ctrl_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.controls_valid == !(rsp_data.failsafe || rsp_data.loss_pending))
      else $error("controls_valid inconsistent with loss state");

   // no response in the first cycle out of reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind rc_pwm_capture_failsafe_unit rcpf_checker u_rcpf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
